// ===== design/swld_pkg.sv =====
// ----------------------------------------------------------------------------
// swld_pkg: shared types and constants for the stable weight latch detector
// Window geometry, field widths, tracker modes, transaction payloads and the
// structs that pass between the tracker, the sample window and the top level.
// ----------------------------------------------------------------------------
package swld_pkg;

    // Window geometry: the depth is a power of two so that means are shifts
    localparam int WIN_LOG2  = 3;
    localparam int WIN_DEPTH = 1 << WIN_LOG2;

    // Field widths
    localparam int W_W       = 16;
    localparam int D_W       = 24;
    localparam int WSQ_W     = 2 * W_W;
    localparam int WSUM_W    = W_W + WIN_LOG2;
    localparam int QSUM_W    = WSQ_W + WIN_LOG2;
    localparam int DSUM_W    = D_W + WIN_LOG2;
    localparam int FILL_W    = WIN_LOG2 + 1;
    localparam int FILL_OUT_W = 4;
    localparam int LIM_W     = W_W + WIN_LOG2;
    localparam int PROD_W    = 2 * WSUM_W;
    localparam int RUN_W     = 8;
    localparam int RDD_W     = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

    // Register reset values
    localparam logic [W_W-1:0]   ENTRY_WEIGHT_RST = 16'd500;
    localparam logic [W_W-1:0]   LEAVE_WEIGHT_RST = 16'd300;
    localparam logic [W_W-1:0]   STD_LIMIT_RST    = 16'd5;
    localparam logic [W_W-1:0]   REARM_WDELTA_RST = 16'd100;
    localparam logic [RDD_W-1:0] REARM_DDELTA_RST = 23'd200;
    localparam logic [RUN_W-1:0] INVALID_GRACE_RST = 8'd3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAVE_WEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STD_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_WDELTA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_DDELTA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_GRACE = 3'd5;

    // Item kinds
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_INVALID = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    typedef enum logic [1:0] {
        MODE_UNSTABLE  = 2'd0,
        MODE_CANDIDATE = 2'd1,
        MODE_LATCHED   = 2'd2
    } mode_t;

    // Input transaction
    typedef struct packed {
        logic [1:0]            kind;
        logic signed [D_W-1:0] sample_distance;
        logic [W_W-1:0]        sample_weight;
    } swld_in_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]            tracker_state;
        logic                  latched_now;
        logic                  cleared_now;
        logic [W_W-1:0]        baseline_weight;
        logic signed [D_W-1:0] baseline_distance;
        logic [FILL_OUT_W-1:0] window_fill;
    } swld_out_t;

    // Configuration as seen by the tracker
    typedef struct packed {
        logic [W_W-1:0]      entry_weight;
        logic [W_W-1:0]      leave_weight;
        logic [W_W-1:0]      rearm_wdelta;
        logic [RDD_W-1:0]    rearm_ddelta;
        logic [RUN_W-1:0]    invalid_grace;
        logic [PROD_W-1:0]   lim_sq;
    } swld_cfg_t;

    // Sample pushed into the window
    typedef struct packed {
        logic           en;
        logic [W_W-1:0] weight;
        logic [D_W-1:0] distance;
    } swld_push_t;

    // Oldest sample of the window
    typedef struct packed {
        logic [W_W-1:0]   weight;
        logic [D_W-1:0]   distance;
        logic [WSQ_W-1:0] weight_sq;
    } swld_tail_t;

endpackage

// ===== design/stable_weight_latch_detector_unit.sv =====
// ----------------------------------------------------------------------------
// stable_weight_latch_detector_unit: stable weight latch detector, top level
// Tracks weight samples in a window of cells and latches the window means as
// a baseline once the spread is small; drops it on change, invalids, clear.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Payload
//  s_        in         s_valid, s_ready, s_data         swld_in_t
//  m_        out        m_valid, m_ready, m_data         swld_out_t
//  cfg_      in         cfg_wr_en, cfg_index, cfg_wdata  register write
//
//  One transaction per cycle sustained while m_ready is high; the result
//  goes from the input register through the tracker update into the output
//  register, where it is held until m_ready takes it.
//  The per-transaction loop is the tracker update: sum update, one 19x19
//  square and the spread compare, all in the tracker stage.
//  Reset: aresetn, synchronous, active low; clears tracker state and both
//  stages, and loads the register defaults. No clearing pass is needed.
//  A stalled result holds in the output register while one more transaction
//  is taken into the input register.
// ----------------------------------------------------------------------------
module stable_weight_latch_detector_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [swld_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swld_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  swld_pkg::swld_in_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output swld_pkg::swld_out_t                  m_data
);

    localparam int W_W = swld_pkg::W_W;
    localparam int L   = swld_pkg::WIN_LOG2;

    logic [W_W-1:0]                   entry_weight_reg;
    logic [W_W-1:0]                   leave_weight_reg;
    logic [W_W-1:0]                   std_limit_reg;
    logic [W_W-1:0]                   rearm_wdelta_reg;
    logic [swld_pkg::RDD_W-1:0]       rearm_ddelta_reg;
    logic [swld_pkg::RUN_W-1:0]       invalid_grace_reg;
    logic [swld_pkg::LIM_W-1:0]       lim;
    logic [swld_pkg::PROD_W-1:0]      lim_sq_reg;
    swld_pkg::swld_cfg_t              cfg;

    logic                             st1_valid_reg;
    swld_pkg::swld_in_t               st1_data_reg;
    logic [swld_pkg::WSQ_W-1:0]       st1_wsq_reg;
    logic                             adv;

    logic                             m_valid_reg;
    swld_pkg::swld_out_t              m_data_reg;

    swld_pkg::swld_push_t             push;
    swld_pkg::swld_tail_t             tail;
    swld_pkg::swld_out_t              result;

    // Decode register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_weight_reg  <= swld_pkg::ENTRY_WEIGHT_RST;
            leave_weight_reg  <= swld_pkg::LEAVE_WEIGHT_RST;
            std_limit_reg     <= swld_pkg::STD_LIMIT_RST;
            rearm_wdelta_reg  <= swld_pkg::REARM_WDELTA_RST;
            rearm_ddelta_reg  <= swld_pkg::REARM_DDELTA_RST;
            invalid_grace_reg <= swld_pkg::INVALID_GRACE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                swld_pkg::CFG_ENTRY_WEIGHT:  entry_weight_reg  <= cfg_wdata[W_W-1:0];
                swld_pkg::CFG_LEAVE_WEIGHT:  leave_weight_reg  <= cfg_wdata[W_W-1:0];
                swld_pkg::CFG_STD_LIMIT:     std_limit_reg     <= cfg_wdata[W_W-1:0];
                swld_pkg::CFG_REARM_WDELTA:  rearm_wdelta_reg  <= cfg_wdata[W_W-1:0];
                swld_pkg::CFG_REARM_DDELTA:  rearm_ddelta_reg  <= cfg_wdata;
                swld_pkg::CFG_INVALID_GRACE:
                    invalid_grace_reg <= cfg_wdata[swld_pkg::RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Square of N times the spread limit, refreshed every cycle
    assign lim = {std_limit_reg, {L{1'b0}}};

    always_ff @(posedge aclk) begin
        lim_sq_reg <= lim * lim;
    end

    assign cfg.entry_weight  = entry_weight_reg;
    assign cfg.leave_weight  = leave_weight_reg;
    assign cfg.rearm_wdelta  = rearm_wdelta_reg;
    assign cfg.rearm_ddelta  = rearm_ddelta_reg;
    assign cfg.invalid_grace = invalid_grace_reg;
    assign cfg.lim_sq        = lim_sq_reg;

    // Advance the tracker stage when the output register is free or draining
    assign adv     = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st1_valid_reg || adv;

    // Input register, with the sample weight squared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            st1_data_reg <= s_data;
            st1_wsq_reg  <= s_data.sample_weight * s_data.sample_weight;
        end
    end

    swld_tracker u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (adv),
        .item     (st1_data_reg),
        .item_wsq (st1_wsq_reg),
        .tail     (tail),
        .push     (push),
        .result   (result)
    );

    swld_window u_window (
        .aclk (aclk),
        .push (push),
        .tail (tail)
    );

    // Output register: load on advance, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/swld_cell.sv =====
// ----------------------------------------------------------------------------
// swld_cell: one slot of the sample window
// Holds one weight and distance and hands them to the next cell on a push.
// ----------------------------------------------------------------------------
module swld_cell (
    input  logic                          aclk,
    input  logic                          shift_en,
    input  logic [swld_pkg::W_W-1:0]      weight_in,
    input  logic [swld_pkg::D_W-1:0]      distance_in,
    output logic [swld_pkg::W_W-1:0]      weight_out,
    output logic [swld_pkg::D_W-1:0]      distance_out
);

    logic [swld_pkg::W_W-1:0] weight_reg;
    logic [swld_pkg::D_W-1:0] distance_reg;

    // Take the previous cell's sample, or the pushed one, on every push
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            weight_reg   <= weight_in;
            distance_reg <= distance_in;
        end
    end

    assign weight_out   = weight_reg;
    assign distance_out = distance_reg;

endmodule

// ===== design/swld_window.sv =====
// ----------------------------------------------------------------------------
// swld_window: chain of sample cells
// A push enters at the head cell and every cell passes its sample on; the
// last cell holds the oldest sample, whose weight square is kept alongside.
// ----------------------------------------------------------------------------
module swld_window (
    input  logic                   aclk,
    input  swld_pkg::swld_push_t   push,
    output swld_pkg::swld_tail_t   tail
);

    logic [swld_pkg::W_W-1:0]   cell_w [swld_pkg::WIN_DEPTH];
    logic [swld_pkg::D_W-1:0]   cell_d [swld_pkg::WIN_DEPTH];
    logic [swld_pkg::WSQ_W-1:0] tail_sq_reg;

    // Build the chain, head fed from the push
    for (genvar i = 0; i < swld_pkg::WIN_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            swld_cell u_cell (
                .aclk         (aclk),
                .shift_en     (push.en),
                .weight_in    (push.weight),
                .distance_in  (push.distance),
                .weight_out   (cell_w[i]),
                .distance_out (cell_d[i])
            );
        end else begin : g_body
            swld_cell u_cell (
                .aclk         (aclk),
                .shift_en     (push.en),
                .weight_in    (cell_w[i-1]),
                .distance_in  (cell_d[i-1]),
                .weight_out   (cell_w[i]),
                .distance_out (cell_d[i])
            );
        end
    end

    // Square the sample that becomes the oldest on this push
    always_ff @(posedge aclk) begin
        if (push.en) begin
            tail_sq_reg <= cell_w[swld_pkg::WIN_DEPTH-2] * cell_w[swld_pkg::WIN_DEPTH-2];
        end
    end

    assign tail.weight    = cell_w[swld_pkg::WIN_DEPTH-1];
    assign tail.distance  = cell_d[swld_pkg::WIN_DEPTH-1];
    assign tail.weight_sq = tail_sq_reg;

endmodule

// ===== design/swld_tracker.sv =====
// ----------------------------------------------------------------------------
// swld_tracker: unstable / candidate / latched tracker
// Keeps the running sums of the window, decides pushes, latches and clears
// for one transaction per step, and forms the result of that transaction.
// ----------------------------------------------------------------------------
module swld_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  swld_pkg::swld_cfg_t             cfg,
    input  logic                            step,
    input  swld_pkg::swld_in_t              item,
    input  logic [swld_pkg::WSQ_W-1:0]      item_wsq,
    input  swld_pkg::swld_tail_t            tail,
    output swld_pkg::swld_push_t            push,
    output swld_pkg::swld_out_t             result
);

    localparam int WSUM_W = swld_pkg::WSUM_W;
    localparam int QSUM_W = swld_pkg::QSUM_W;
    localparam int DSUM_W = swld_pkg::DSUM_W;
    localparam int FILL_W = swld_pkg::FILL_W;
    localparam int PROD_W = swld_pkg::PROD_W;
    localparam int W_W    = swld_pkg::W_W;
    localparam int D_W    = swld_pkg::D_W;
    localparam int L      = swld_pkg::WIN_LOG2;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(swld_pkg::WIN_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
    localparam logic [WSUM_W-1:0] WSUM_HALF = WSUM_W'(swld_pkg::WIN_DEPTH / 2);
    localparam logic [DSUM_W-1:0] DSUM_HALF = DSUM_W'(swld_pkg::WIN_DEPTH / 2);

    swld_pkg::mode_t             mode_reg,   mode_next;
    logic [FILL_W-1:0]           fill_reg,   fill_next;
    logic [WSUM_W-1:0]           wsum_reg,   wsum_next;
    logic [QSUM_W-1:0]           qsum_reg,   qsum_next;
    logic [DSUM_W-1:0]           dsum_reg,   dsum_next;
    logic [W_W-1:0]              held_w_reg, held_w_next;
    logic [D_W-1:0]              held_d_reg, held_d_next;
    logic [swld_pkg::RUN_W-1:0]  run_reg,    run_next;

    logic                        restart;
    logic                        full;
    logic                        drop;
    logic [WSUM_W-1:0]           wsum_new;
    logic [QSUM_W-1:0]           qsum_new;
    logic [DSUM_W-1:0]           dsum_new;
    logic [FILL_W-1:0]           fill_new;
    logic [PROD_W-1:0]           wsum_sq;
    logic [PROD_W:0]             spread;
    logic                        steady;
    logic [WSUM_W-1:0]           wsum_round;
    logic [DSUM_W-1:0]           dsum_round;
    logic [W_W:0]                dw;
    logic [W_W:0]                dw_abs;
    logic [D_W:0]                dd;
    logic [D_W:0]                dd_abs;
    logic                        must_clear;
    logic                        entry_hit;
    logic [swld_pkg::RUN_W-1:0]  run_inc;
    logic                        do_clear;
    logic                        do_begin;
    logic                        do_latch;
    logic                        latched;
    logic                        cleared;

    // Sums after pushing this sample, fresh window when not a candidate
    assign restart  = (mode_reg != swld_pkg::MODE_CANDIDATE);
    assign full     = (fill_reg == FILL_FULL);
    assign drop     = !restart && full;
    assign wsum_new = (restart ? '0 : wsum_reg) + WSUM_W'(item.sample_weight)
                      - (drop ? WSUM_W'(tail.weight) : '0);
    assign qsum_new = (restart ? '0 : qsum_reg) + QSUM_W'(item_wsq)
                      - (drop ? QSUM_W'(tail.weight_sq) : '0);
    assign dsum_new = (restart ? '0 : dsum_reg)
                      + {{L{item.sample_distance[D_W-1]}}, item.sample_distance}
                      - (drop ? {{L{tail.distance[D_W-1]}}, tail.distance} : '0);
    assign fill_new = restart ? FILL_ONE : (full ? fill_reg : fill_reg + FILL_ONE);

    // Spread test: N*sum(w^2) - (sum w)^2 against (N*limit)^2
    assign wsum_sq = wsum_new * wsum_new;
    assign spread  = {1'b0, qsum_new, {L{1'b0}}} - {1'b0, wsum_sq};
    assign steady  = spread[PROD_W] || (spread[PROD_W-1:0] < cfg.lim_sq);

    // Rounded means, ties upward
    assign wsum_round = wsum_new + WSUM_HALF;
    assign dsum_round = dsum_new + DSUM_HALF;

    // Distance from the baseline
    assign dw     = {1'b0, item.sample_weight} - {1'b0, held_w_reg};
    assign dw_abs = dw[W_W] ? (~dw + 1'b1) : dw;
    assign dd     = {item.sample_distance[D_W-1], item.sample_distance}
                    - {held_d_reg[D_W-1], held_d_reg};
    assign dd_abs = dd[D_W] ? (~dd + 1'b1) : dd;

    assign must_clear = (item.sample_weight < cfg.leave_weight)
                        || (dw_abs >= {1'b0, cfg.rearm_wdelta})
                        || (dd_abs >= (D_W + 1)'(cfg.rearm_ddelta));
    assign entry_hit  = (item.sample_weight > cfg.entry_weight);
    assign run_inc    = (run_reg != swld_pkg::RUN_MAX) ? run_reg + 1'b1 : run_reg;

    // Decide what this transaction does
    always_comb begin
        do_clear = 1'b0;
        do_begin = 1'b0;
        do_latch = 1'b0;
        cleared  = 1'b0;
        run_next = run_reg;
        case (item.kind)
            swld_pkg::KIND_SAMPLE: begin
                run_next = '0;
                if (mode_reg == swld_pkg::MODE_LATCHED) begin
                    if (must_clear) begin
                        do_clear = 1'b1;
                        cleared  = 1'b1;
                        do_begin = entry_hit;
                    end
                end else if (!entry_hit) begin
                    if (mode_reg == swld_pkg::MODE_CANDIDATE) begin
                        do_clear = 1'b1;
                        cleared  = 1'b1;
                    end
                end else begin
                    do_begin = 1'b1;
                    do_latch = (fill_new == FILL_FULL) && steady;
                end
            end
            swld_pkg::KIND_INVALID: begin
                if (mode_reg == swld_pkg::MODE_CANDIDATE) begin
                    do_clear = 1'b1;
                    cleared  = 1'b1;
                end else if (mode_reg == swld_pkg::MODE_LATCHED) begin
                    run_next = run_inc;
                    if (run_inc >= cfg.invalid_grace) begin
                        do_clear = 1'b1;
                        cleared  = 1'b1;
                    end
                end
            end
            swld_pkg::KIND_CLEAR: begin
                do_clear = 1'b1;
                cleared  = (mode_reg != swld_pkg::MODE_UNSTABLE);
            end
            default: begin
            end
        endcase
    end

    // Apply clear, then candidate push, then latch
    always_comb begin
        mode_next   = mode_reg;
        fill_next   = fill_reg;
        wsum_next   = wsum_reg;
        qsum_next   = qsum_reg;
        dsum_next   = dsum_reg;
        held_w_next = held_w_reg;
        held_d_next = held_d_reg;
        latched     = 1'b0;
        if (do_clear) begin
            mode_next   = swld_pkg::MODE_UNSTABLE;
            fill_next   = '0;
            wsum_next   = '0;
            qsum_next   = '0;
            dsum_next   = '0;
            held_w_next = '0;
            held_d_next = '0;
        end
        if (do_begin) begin
            mode_next = swld_pkg::MODE_CANDIDATE;
            fill_next = fill_new;
            wsum_next = wsum_new;
            qsum_next = qsum_new;
            dsum_next = dsum_new;
        end
        if (do_latch) begin
            mode_next   = swld_pkg::MODE_LATCHED;
            held_w_next = wsum_round[WSUM_W-1:L];
            held_d_next = dsum_round[DSUM_W-1:L];
            latched     = 1'b1;
        end
    end

    // Hold tracker state, advance on each step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= swld_pkg::MODE_UNSTABLE;
            fill_reg   <= '0;
            wsum_reg   <= '0;
            qsum_reg   <= '0;
            dsum_reg   <= '0;
            held_w_reg <= '0;
            held_d_reg <= '0;
            run_reg    <= '0;
        end else if (step) begin
            mode_reg   <= mode_next;
            fill_reg   <= fill_next;
            wsum_reg   <= wsum_next;
            qsum_reg   <= qsum_next;
            dsum_reg   <= dsum_next;
            held_w_reg <= held_w_next;
            held_d_reg <= held_d_next;
            run_reg    <= do_clear ? '0 : run_next;
        end
    end

    assign push.en       = step && do_begin;
    assign push.weight   = item.sample_weight;
    assign push.distance = item.sample_distance;

    assign result.tracker_state     = mode_next;
    assign result.latched_now       = latched;
    assign result.cleared_now       = cleared;
    assign result.baseline_weight   = held_w_next;
    assign result.baseline_distance = held_d_next;
    assign result.window_fill       = swld_pkg::FILL_OUT_W'(fill_next);

endmodule
